[rtl/psts_pkg.sv]
// Package: shared widths, register indexes, mode codes and limits of the purge test sequencer.
`default_nettype none
package psts_pkg;

  localparam int unsigned CodeW     = 8;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned TimeCfgW  = 16;
  localparam int unsigned TimeW     = 9;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned PosW      = 8;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned ApbAddrW  = 5;
  localparam int unsigned RegIdxW   = 3;

  localparam logic [IntervalW-1:0] IntervalClamp = 8'd250;
  localparam logic [TimeW-1:0]     TimeClamp     = 9'd500;
  localparam logic [PosW-1:0]      PosOpen       = 8'd255;
  localparam logic [PosW-1:0]      PosClosed     = 8'd0;

  // Register indexes, byte address is four times the index.
  localparam logic [RegIdxW-1:0] RegPurgeCode = 3'd0;
  localparam logic [RegIdxW-1:0] RegOnTime    = 3'd1;
  localparam logic [RegIdxW-1:0] RegOffTime   = 3'd2;
  localparam logic [RegIdxW-1:0] RegTotalTime = 3'd3;
  localparam logic [RegIdxW-1:0] RegHoldTime  = 3'd4;

  localparam logic [ModeW-1:0] ModeIdle   = 2'd0;
  localparam logic [ModeW-1:0] ModeOpen   = 2'd1;
  localparam logic [ModeW-1:0] ModeClosed = 2'd2;
  localparam logic [ModeW-1:0] ModeEnd    = 2'd3;

  typedef struct packed {
    logic [ModeW-1:0] test_state;
    logic             power_relay_cmd;
    logic [PosW-1:0]  position_setpoint;
    logic             test_complete;
  } result_t;

endpackage
`default_nettype wire

[rtl/psts_if.sv]
// Interfaces: valid/ready channels for tick requests and result requests.
`default_nettype none
interface psts_in_if
  import psts_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] test_code;
  logic             service_enable;

  modport source (output valid, output test_code, output service_enable, input ready);
  modport sink   (input valid, input test_code, input service_enable, output ready);
endinterface

interface psts_out_if
  import psts_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] test_state;
  logic             power_relay_cmd;
  logic [PosW-1:0]  position_setpoint;
  logic             test_complete;

  modport source (output valid, output test_state, output power_relay_cmd,
                  output position_setpoint, output test_complete, input ready);
  modport sink   (input valid, input test_state, input power_relay_cmd,
                  input position_setpoint, input test_complete, output ready);
endinterface
`default_nettype wire

[rtl/purge_actuator_test_sequencer_top.sv]
// Top level: purge actuator test sequencer with APB register port and output register.
//
//   Channel  Dir  Handshake           Payload
//   in_i     in   valid/ready         test_code, service_enable
//   out_o    out  valid/ready         test_state, power_relay_cmd, position_setpoint,
//                                     test_complete
//   APB      in   psel/penable/pready purge_test_code, on_time, off_time, total_time,
//                                     end_hold_time
//
// One request is taken per cycle while in_i.ready is high; its result shows on out_o
// in the cycle after it is taken. The sequencer state and the result register both load at
// the accepting edge. A new request is taken while the result register is empty or being
// drained, so a stall on out_o holds the input only while a result is waiting.
// Reset clears the mode, counters, registers and the result valid bit.
`default_nettype none
module purge_actuator_test_sequencer_top
  import psts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  psts_in_if.sink                  in_i,
  psts_out_if.source               out_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output logic      [ApbDataW-1:0] prdata,
  output logic                     pready
);

  logic [CodeW-1:0]     purge_code_q;
  logic [IntervalW-1:0] on_time_q;
  logic [IntervalW-1:0] off_time_q;
  logic [TimeCfgW-1:0]  total_time_q;
  logic [TimeCfgW-1:0]  hold_time_q;

  logic [ModeW-1:0]     mode_q, mode_d;
  logic [IntervalW-1:0] interval_q, interval_d;
  logic [TimeW-1:0]     total_q, total_d;
  logic [TimeW-1:0]     hold_q, hold_d;

  logic    out_valid_q;
  result_t result_q, result_d;

  logic                 in_fire;
  logic                 enabled;
  logic [RegIdxW-1:0]   reg_idx;
  logic [IntervalW-1:0] on_clamp, off_clamp;
  logic [TimeW-1:0]     total_clamp, hold_clamp;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      purge_code_q <= '0;
      on_time_q    <= '0;
      off_time_q   <= '0;
      total_time_q <= '0;
      hold_time_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegPurgeCode: purge_code_q <= pwdata[CodeW-1:0];
        RegOnTime:    on_time_q    <= pwdata[IntervalW-1:0];
        RegOffTime:   off_time_q   <= pwdata[IntervalW-1:0];
        RegTotalTime: total_time_q <= pwdata[TimeCfgW-1:0];
        RegHoldTime:  hold_time_q  <= pwdata[TimeCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegPurgeCode: prdata = {{(ApbDataW-CodeW){1'b0}}, purge_code_q};
      RegOnTime:    prdata = {{(ApbDataW-IntervalW){1'b0}}, on_time_q};
      RegOffTime:   prdata = {{(ApbDataW-IntervalW){1'b0}}, off_time_q};
      RegTotalTime: prdata = {{(ApbDataW-TimeCfgW){1'b0}}, total_time_q};
      RegHoldTime:  prdata = {{(ApbDataW-TimeCfgW){1'b0}}, hold_time_q};
      default:      prdata = '0;
    endcase
  end

  assign on_clamp    = (on_time_q > IntervalClamp) ? IntervalClamp : on_time_q;
  assign off_clamp   = (off_time_q > IntervalClamp) ? IntervalClamp : off_time_q;
  assign total_clamp = (total_time_q > {{(TimeCfgW-TimeW){1'b0}}, TimeClamp}) ?
                       TimeClamp : total_time_q[TimeW-1:0];
  assign hold_clamp  = (hold_time_q > {{(TimeCfgW-TimeW){1'b0}}, TimeClamp}) ?
                       TimeClamp : hold_time_q[TimeW-1:0];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;
  assign enabled    = in_i.service_enable && (in_i.test_code == purge_code_q);

  always_comb begin
    mode_d     = mode_q;
    interval_d = interval_q;
    total_d    = total_q;
    hold_d     = hold_q;
    case (mode_q)
      ModeIdle: begin
        if (enabled) begin
          mode_d     = ModeOpen;
          interval_d = on_clamp;
          total_d    = total_clamp;
        end
      end
      ModeOpen, ModeClosed: begin
        if (!enabled) begin
          mode_d = ModeIdle;
        end else if (total_q <= 9'd1) begin
          mode_d = ModeEnd;
          hold_d = hold_clamp;
        end else begin
          // A zero interval reload behaves like one: the phase flips next tick.
          if (interval_q <= 8'd1) begin
            if (mode_q == ModeOpen) begin
              mode_d     = ModeClosed;
              interval_d = off_clamp;
            end else begin
              mode_d     = ModeOpen;
              interval_d = on_clamp;
            end
          end else begin
            interval_d = interval_q - 8'd1;
          end
          total_d = total_q - 9'd1;
        end
      end
      ModeEnd: begin
        // Only an enabled request with the hold count at zero releases the end state.
        if (enabled && hold_q == '0) begin
          mode_d = ModeIdle;
        end else if (hold_q != '0) begin
          hold_d = hold_q - 9'd1;
        end
      end
      default: mode_d = ModeIdle;
    endcase
  end

  // The relay, valve and complete flags follow directly from the mode.
  always_comb begin
    result_d.test_state        = mode_d;
    result_d.power_relay_cmd   = (mode_d == ModeOpen) || (mode_d == ModeClosed);
    result_d.position_setpoint = (mode_d == ModeOpen) ? PosOpen : PosClosed;
    result_d.test_complete     = (mode_d == ModeEnd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeIdle;
      interval_q  <= '0;
      total_q     <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q     <= mode_d;
        interval_q <= interval_d;
        total_q    <= total_d;
        hold_q     <= hold_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.test_state        = result_q.test_state;
  assign out_o.power_relay_cmd   = result_q.power_relay_cmd;
  assign out_o.position_setpoint = result_q.position_setpoint;
  assign out_o.test_complete     = result_q.test_complete;

endmodule
`default_nettype wire
